/* hw/rtl/eudst_pkg.sv */
// ----------------------------------------------------------------------------
// eudst_pkg
// Shared types, constants and helper functions for the summer-time check.
// ----------------------------------------------------------------------------
package eudst_pkg;

	// Reciprocal of 100: floor(y * 5243 / 2^19) == floor(y / 100) for y < 2^14
	localparam logic [12:0] Recip100   = 13'd5243;
	localparam int          RecipShift = 19;

	localparam logic [3:0] MonthJan = 4'd1;
	localparam logic [3:0] MonthFeb = 4'd2;
	localparam logic [3:0] MonthMar = 4'd3;
	localparam logic [3:0] MonthOct = 4'd10;

	localparam logic [4:0] LastDay    = 5'd31;
	localparam logic [4:0] SpringHour = 5'd3;
	localparam logic [4:0] FallHour   = 5'd4;

	// Sakamoto offsets of March and October, with day 31 folded in (mod 7)
	localparam logic [2:0] MarLastKey = 3'd5;  // (2 + 31) mod 7
	localparam logic [2:0] OctLastKey = 3'd2;  // (6 + 31) mod 7

	localparam logic signed [1:0] AdjNone = 2'sb00;
	localparam logic signed [1:0] AdjFwd  = 2'sb01;
	localparam logic signed [1:0] AdjBack = 2'sb11;

	typedef struct packed {
		logic s2;
		logic s3;
	} eudst_en_t;

	// Sakamoto month offset; months outside 1..12 give 0
	function automatic logic [2:0] month_offset(input logic [3:0] m);
		logic [2:0] off;
		case (m)
			4'd1:    off = 3'd0;
			4'd2:    off = 3'd3;
			4'd3:    off = 3'd2;
			4'd4:    off = 3'd5;
			4'd5:    off = 3'd0;
			4'd6:    off = 3'd3;
			4'd7:    off = 3'd5;
			4'd8:    off = 3'd1;
			4'd9:    off = 3'd4;
			4'd10:   off = 3'd6;
			4'd11:   off = 3'd2;
			4'd12:   off = 3'd4;
			default: off = 3'd0;
		endcase
		return off;
	endfunction

	// Modulo 7 by octal digit folding (8 == 1 mod 7)
	function automatic logic [2:0] mod7(input logic [15:0] v);
		logic [5:0] s;
		logic [3:0] t;
		s = 6'(v[2:0]) + 6'(v[5:3]) + 6'(v[8:6]) + 6'(v[11:9]) + 6'(v[14:12])
			+ 6'(v[15]);
		t = 4'(s[2:0]) + 4'(s[5:3]);
		if (t >= 4'd7) begin
			t = t - 4'd7;
		end
		return t[2:0];
	endfunction

endpackage

/* hw/rtl/eudst_year_key.sv */
// ----------------------------------------------------------------------------
// eudst_year_key
// Two-stage year term of Sakamoto's formula:
// (y + y/4 - y/100 + y/400) mod 7.
// ----------------------------------------------------------------------------
module eudst_year_key (
	input  logic                 clk,
	input  logic                 arst_n,
	input  eudst_pkg::eudst_en_t en,
	input  logic [13:0]          year,
	output logic [2:0]           key_s3
);

	logic [26:0] prod;
	logic [13:0] year_s2;
	logic [7:0]  q100_s2;
	logic [14:0] sum;

	// y / 100 via reciprocal multiply
	assign prod = 27'(year) * 27'(eudst_pkg::Recip100);

	// q/4 == y/400 since floor(floor(y/100)/4) == floor(y/400)
	assign sum = 15'(year_s2) + 15'(year_s2 >> 2) - 15'(q100_s2) + 15'(q100_s2 >> 2);

	// payload only, no reset needed
	always_ff @(posedge clk) begin
		if (en.s2) begin
			year_s2 <= year;
			q100_s2 <= prod[eudst_pkg::RecipShift +: 8];
		end
		if (en.s3) begin
			key_s3 <= eudst_pkg::mod7(16'(sum));
		end
	end

`ifndef SYNTHESIS
	// quotient estimate stays within the range of a 14-bit year over 100
	a_q_range: assert property (@(posedge clk) disable iff (!arst_n)
		$past(en.s2) |-> q100_s2 <= 8'd163)
		else $error("year/100 estimate out of range");

	// the residue is a proper modulo-7 value
	a_key_range: assert property (@(posedge clk) disable iff (!arst_n)
		$past(en.s3) |-> key_s3 != 3'd7)
		else $error("year key not reduced mod 7");

	// after a stage 2 load the year is never below its hundreds quotient
	a_sum_bound: assert property (@(posedge clk) disable iff (!arst_n)
		$past(en.s2) |-> ({1'b0, year_s2} >= {7'd0, q100_s2}))
		else $error("year below its hundreds quotient");
`endif

endmodule

/* hw/rtl/eu_dst_transition_check.sv */
// ----------------------------------------------------------------------------
// eu_dst_transition_check
// European summer-time rule check for one date and hour per transaction.
//
// Each input transaction carries a Gregorian date, a local hour and the
// caller's current summer-time flag; the block returns the rule's verdict,
// the weekday of the date (0 Sunday) and an hour adjustment (+1 at hour 3
// with the flag clear when summer applies, -1 at hour 4 with the flag set
// when winter applies, else 0). The last Sundays of March and October come
// from Sakamoto's formula on the 31st. The block is a four-stage pipeline
// with no kept state: one transaction is taken per cycle while out_ready
// stays high, and each result is registered through stages 1 to 4 before
// it is offered on out_valid.
// Stage 1 registers the inputs and the Jan/Feb year shift, stage 2 the
// reciprocal multiply for y/100, stage 3 the mod-7 year terms and stage 4
// the weekdays, rule compares and the output register. out_ready low
// back-pressures stage by stage, and empty stages keep filling.
// ----------------------------------------------------------------------------
module eu_dst_transition_check (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [13:0]       year_full,
	input  logic [3:0]        month_num,
	input  logic [4:0]        day_of_month,
	input  logic [4:0]        hour_local,
	input  logic              dst_active_now,
	output logic              out_valid,
	input  logic              out_ready,
	output logic signed [1:0] hour_adjust,
	output logic              dst_in_effect,
	output logic [2:0]        weekday
);

	// stage advance: a stage moves when it is empty or its successor moves
	logic adv_s1, adv_s2, adv_s3, adv_s4;
	logic vld_s1, vld_s2, vld_s3, vld_s4;
	eudst_pkg::eudst_en_t en;

	assign adv_s4   = !vld_s4 || out_ready;
	assign adv_s3   = !vld_s3 || adv_s4;
	assign adv_s2   = !vld_s2 || adv_s3;
	assign adv_s1   = !vld_s1 || adv_s2;
	assign in_ready = adv_s1;
	assign en       = '{s2: adv_s2, s3: adv_s3};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else begin
			if (adv_s1) begin
				vld_s1 <= in_valid;
			end
			if (adv_s2) begin
				vld_s2 <= vld_s1;
			end
			if (adv_s3) begin
				vld_s3 <= vld_s2;
			end
			if (adv_s4) begin
				vld_s4 <= vld_s3;
			end
		end
	end

	// ---- stage 1: capture, date year shifted back for Jan/Feb ----
	logic [13:0] year_s1, date_year_s1;
	logic [3:0]  month_s1;
	logic [4:0]  day_s1, hour_s1;
	logic        flag_s1;
	logic [2:0]  moff_s1;
	logic        early_month;

	assign early_month = (month_num == eudst_pkg::MonthJan)
		|| (month_num == eudst_pkg::MonthFeb);

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			year_s1      <= year_full;
			date_year_s1 <= (early_month && (year_full != 14'd0))
				? year_full - 14'd1 : year_full;
			month_s1     <= month_num;
			day_s1       <= day_of_month;
			hour_s1      <= hour_local;
			flag_s1      <= dst_active_now;
			moff_s1      <= eudst_pkg::month_offset(month_num);
		end
	end

	// ---- stages 2 and 3: year terms for the rule year and the date year ----
	logic [2:0] rule_key_s3, date_key_s3;

	eudst_year_key u_rule_key (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.year   (year_s1),
		.key_s3 (rule_key_s3)
	);

	eudst_year_key u_date_key (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.year   (date_year_s1),
		.key_s3 (date_key_s3)
	);

	// side payload travels alongside the year units
	logic [3:0] month_s2, month_s3;
	logic [4:0] day_s2, day_s3, hour_s2, hour_s3;
	logic       flag_s2, flag_s3;
	logic [2:0] moff_s2, moff_s3;

	always_ff @(posedge clk) begin
		if (adv_s2) begin
			month_s2 <= month_s1;
			day_s2   <= day_s1;
			hour_s2  <= hour_s1;
			flag_s2  <= flag_s1;
			moff_s2  <= moff_s1;
		end
		if (adv_s3) begin
			month_s3 <= month_s2;
			day_s3   <= day_s2;
			hour_s3  <= hour_s2;
			flag_s3  <= flag_s2;
			moff_s3  <= moff_s2;
		end
	end

	// ---- stage 4: weekdays, last Sundays, rule and adjustment ----
	logic [2:0]        wd_date, wd_mar, wd_oct;
	logic [4:0]        begin_day, end_day;
	logic              summer;
	logic              at_switch;
	logic signed [1:0] adj;

	assign wd_date = eudst_pkg::mod7(16'(date_key_s3) + 16'(moff_s3) + 16'(day_s3));
	assign wd_mar  = eudst_pkg::mod7(16'(rule_key_s3) + 16'(eudst_pkg::MarLastKey));
	assign wd_oct  = eudst_pkg::mod7(16'(rule_key_s3) + 16'(eudst_pkg::OctLastKey));

	assign begin_day = eudst_pkg::LastDay - 5'(wd_mar);
	assign end_day   = eudst_pkg::LastDay - 5'(wd_oct);

	always_comb begin
		if ((month_s3 > eudst_pkg::MonthMar) && (month_s3 < eudst_pkg::MonthOct)) begin
			summer = 1'b1;
		end else if (month_s3 == eudst_pkg::MonthMar) begin
			summer = (day_s3 > begin_day)
				|| ((day_s3 == begin_day) && (hour_s3 >= eudst_pkg::SpringHour));
		end else if (month_s3 == eudst_pkg::MonthOct) begin
			summer = (day_s3 < end_day)
				|| ((day_s3 == end_day) && (hour_s3 < eudst_pkg::FallHour));
		end else begin
			summer = 1'b0;
		end
	end

	// adjustment only at the switch hour that matches the caller's flag
	assign at_switch = ((hour_s3 == eudst_pkg::SpringHour) && !flag_s3)
		|| ((hour_s3 == eudst_pkg::FallHour) && flag_s3);

	always_comb begin
		adj = eudst_pkg::AdjNone;
		if (at_switch) begin
			if (summer && !flag_s3) begin
				adj = eudst_pkg::AdjFwd;
			end else if (!summer && flag_s3) begin
				adj = eudst_pkg::AdjBack;
			end
		end
	end

	logic signed [1:0] adj_s4;
	logic              summer_s4;
	logic [2:0]        wd_s4;

	always_ff @(posedge clk) begin
		if (adv_s4) begin
			adj_s4    <= adj;
			summer_s4 <= summer;
			wd_s4     <= wd_date;
		end
	end

	assign out_valid     = vld_s4;
	assign hour_adjust   = adj_s4;
	assign dst_in_effect = summer_s4;
	assign weekday       = wd_s4;

`ifndef SYNTHESIS
	// an empty output register never blocks the input side
	a_no_false_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled with output stage empty");

	// spring forward only ever comes with a summer verdict
	a_fwd_summer: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (hour_adjust == eudst_pkg::AdjFwd)) |-> dst_in_effect)
		else $error("forward adjust without summer time");

	// fall back only ever comes with a winter verdict
	a_back_winter: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (hour_adjust == eudst_pkg::AdjBack)) |-> !dst_in_effect)
		else $error("back adjust during summer time");

	// no unused adjust code, weekday reduced
	a_out_codes: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ((hour_adjust != 2'sb10) && (weekday != 3'd7)))
		else $error("output code out of range");

	// a held result keeps the pipeline behind it frozen when it is full
	a_full_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s1 && vld_s2 && vld_s3 && vld_s4 && !out_ready) |-> !in_ready)
		else $error("full pipeline accepted a transaction under stall");
`endif

endmodule
